// ===== sv/rps_pkg.sv =====
`timescale 1ns / 1ps

package rps_pkg;

    localparam int MAX_SIZE = 256;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int VAL_W    = IDX_W + 1;
    localparam int WORD_W   = 31;
    localparam int STEP_W   = $clog2(WORD_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_DONE
    } t_state;

    // start request for the remainder unit
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [VAL_W-1:0]  divisor;
    } t_div_req;

endpackage

// ===== sv/rps_in_if.sv =====
`timescale 1ns / 1ps

interface rps_in_if import rps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink (input valid, input random_word, output ready);
endinterface

// ===== sv/rps_out_if.sv =====
`timescale 1ns / 1ps

interface rps_out_if import rps_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] position;
    logic             last_of_perm;

    modport source (output valid, output value, output position, output last_of_perm,
                    input ready);
    modport sink (input valid, input value, input position, input last_of_perm,
                  output ready);
endinterface

// ===== sv/rps_cfg_if.sv =====
`timescale 1ns / 1ps

interface rps_cfg_if import rps_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] perm_size;

    modport source (output valid, output perm_size, input ready);
    modport sink (input valid, input perm_size, output ready);
endinterface

// ===== sv/rps_mod_unit.sv =====
`timescale 1ns / 1ps

// Restoring remainder, one dividend bit per cycle.
module rps_mod_unit import rps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [VAL_W-1:0] o_remainder
);

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [WORD_W-1:0] r_word;
    logic [VAL_W-1:0]  r_rem;
    logic [VAL_W-1:0]  r_div;
    logic              r_done;

    logic [VAL_W:0]    n_trial;
    logic [VAL_W-1:0]  n_rem;

    always_comb begin
        n_trial = {r_rem, r_word[WORD_W-1]};
        if (n_trial >= {1'b0, r_div}) begin
            n_rem = VAL_W'(n_trial - {1'b0, r_div});
        end else begin
            n_rem = n_trial[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == STEP_W'(WORD_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_word <= i_req.dividend;
            r_div  <= i_req.divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_word <= {r_word[WORD_W-2:0], 1'b0};
            r_rem  <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

// ===== sv/random_permutation_shuffle.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                          Transfer
// i_item    in   random_word[30:0]                valid & ready
// o_result  out  value[8:0] position[7:0] last    valid & ready
// i_cfg     in   perm_size[8:0]                   valid & ready
//
// One item holds the block from one input transfer to the next: the accept
// cycle, the divide step (31 dividend bits, one per cycle, then the done
// flag), then 4 steps on the slot memory (read i, read j, write i, write j).
// The result is loaded into the output register as the item leaves its last step.
// Reset (i_rst_n low, synchronous) sets the size to 256, position 0 and marks
// every slot unwritten; the slot memory itself needs no clearing.
// A result waits in the output register; a stalled sink holds the block in its
// last step only once the next item has finished. A pending size write takes
// priority over a new item and waits for the output register to drain.
module random_permutation_shuffle import rps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rps_in_if.sink   i_item,
    rps_out_if.source o_result,
    rps_cfg_if.sink  i_cfg
);

    t_state r_state, n_state;

    logic [VAL_W-1:0]    r_size;
    logic [IDX_W-1:0]    r_pos;
    logic [MAX_SIZE-1:0] r_slot_ok;   // slot written in current permutation
    logic [VAL_W-1:0]    r_slot_mem [MAX_SIZE];
    logic [VAL_W-1:0]    r_mem_q;
    logic [IDX_W-1:0]    r_j;
    logic [VAL_W-1:0]    r_a;
    logic [VAL_W-1:0]    r_b;

    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    logic [IDX_W-1:0] r_out_pos;
    logic             r_out_last;

    logic [VAL_W-1:0] eff_n;
    logic [VAL_W-1:0] rem_cnt;
    logic             is_last;
    logic             cfg_xfer;
    logic             in_xfer;

    t_div_req         div_req;
    logic             div_done;
    logic [VAL_W-1:0] div_rem;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [VAL_W-1:0] b_now;
    logic             set_i;
    logic             set_j;
    logic             retire;

    // size 0 acts as 1, anything past the store acts as the store size
    always_comb begin
        if (r_size == '0) begin
            eff_n = VAL_W'(1);
        end else if (r_size > VAL_W'(MAX_SIZE)) begin
            eff_n = VAL_W'(MAX_SIZE);
        end else begin
            eff_n = r_size;
        end
    end

    assign rem_cnt  = eff_n - {1'b0, r_pos};
    assign is_last  = ({1'b0, r_pos} + 1'b1) == eff_n;

    // size write wins over an item offered in the same cycle
    assign i_item.ready = (r_state == ST_IDLE) && !i_cfg.valid;
    assign i_cfg.ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign in_xfer      = i_item.valid && i_item.ready;
    assign cfg_xfer     = i_cfg.valid && i_cfg.ready;

    assign div_req.start    = in_xfer;
    assign div_req.dividend = i_item.random_word;
    assign div_req.divisor  = rem_cnt;

    rps_mod_unit u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (div_req),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    // unwritten slot reads as its identity value k+1
    assign b_now = r_slot_ok[r_j] ? r_mem_q : ({1'b0, r_j} + 1'b1);

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = b_now;
        mem_raddr = r_pos;
        set_i     = 1'b0;
        set_j     = 1'b0;
        retire    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: begin
                mem_raddr = r_pos;
                n_state   = ST_RD_J;
            end
            ST_RD_J: begin
                mem_raddr = r_j;
                n_state   = ST_WR_I;
            end
            ST_WR_I: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = b_now;
                set_i     = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                // repeated while the output register is full; same data each time
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_a;
                set_j     = 1'b1;
                if (!r_out_valid || o_result.ready) begin
                    retire  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_slot_mem[mem_raddr];
    end

    // datapath captures
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && div_done) begin
            r_j <= IDX_W'({1'b0, r_pos} + div_rem);
        end
        if (r_state == ST_RD_J) begin
            r_a <= r_slot_ok[r_pos] ? r_mem_q : ({1'b0, r_pos} + 1'b1);
        end
        if (r_state == ST_WR_I) begin
            r_b <= b_now;
        end
    end

    // size, position and slot-written bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= VAL_W'(MAX_SIZE);
            r_pos     <= '0;
            r_slot_ok <= '0;
        end else if (cfg_xfer) begin
            r_size    <= i_cfg.perm_size;
            r_pos     <= '0;
            r_slot_ok <= '0;
        end else if (retire && is_last) begin
            // new permutation: everything reads as identity again
            r_pos     <= '0;
            r_slot_ok <= '0;
        end else begin
            if (set_i) begin
                r_slot_ok[r_pos] <= 1'b1;
            end
            if (set_j) begin
                r_slot_ok[r_j] <= 1'b1;
            end
            if (retire) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (retire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (retire) begin
            r_out_value <= r_b;
            r_out_pos   <= r_pos;
            r_out_last  <= is_last;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.value        = r_out_value;
    assign o_result.position     = r_out_pos;
    assign o_result.last_of_perm = r_out_last;

    // once an item is taken, no other is taken until it retires
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_item.ready)
        else $error("item accepted while previous item in flight");

    // remainder unit finishes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("remainder done outside divide step");

    // last flag agrees with position and size
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |->
            (o_result.last_of_perm == (({1'b0, o_result.position} + 1'b1) == eff_n)))
        else $error("last flag does not match position");

    // emitted value stays within 1..N
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.value != '0) && (o_result.value <= eff_n))
        else $error("value out of range");

endmodule
